// ----- rtl/dstq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and constants for the deadline-sorted task queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ID_W    = 32;
  localparam int unsigned DL_W    = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic apply;
  } cmd_t;

endpackage

// ----- rtl/dstq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstq_ctrl
// Two-step sequencer: capture the item and its compares, then apply it.
// ----------------------------------------------------------------------------
module dstq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           done_o,
  output dstq_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_comb begin
    cmd_o.capture = start_i && !busy_q;
    cmd_o.apply   = (state_q == S_APPLY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_APPLY;
            busy_q  <= 1'b1;
          end
        end
        S_APPLY: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_apply_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> done_q && !busy_q)
    else $error("apply step did not finish in one cycle");
  a_done_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("result strobe without an apply step");
  a_busy_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q == S_APPLY))
    else $error("busy out of step with state");
`endif

endmodule

// ----- rtl/dstq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstq_datapath
// Sorted cell chain: per-cell compares, then one shift step to insert/remove.
// ----------------------------------------------------------------------------
module dstq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dstq_pkg::cmd_t                      cmd_i,
  input  logic                                action_i,
  input  logic [dstq_pkg::ID_W-1:0]           task_id_i,
  input  logic [dstq_pkg::DL_W-1:0]           deadline_i,
  output logic [dstq_pkg::STAT_W-1:0]         status_o,
  output logic [dstq_pkg::COUNT_W-1:0]        entry_count_o
);

  localparam int unsigned N = dstq_pkg::DEPTH;

  logic [dstq_pkg::ID_W-1:0]  ids_q [N];
  logic [dstq_pkg::ID_W-1:0]  ids_d [N];
  logic [dstq_pkg::DL_W-1:0]  dls_q [N];
  logic [dstq_pkg::DL_W-1:0]  dls_d [N];
  logic [dstq_pkg::ID_W-1:0]  ids_dn [N];
  logic [dstq_pkg::DL_W-1:0]  dls_dn [N];
  logic [dstq_pkg::ID_W-1:0]  ids_up [N];
  logic [dstq_pkg::DL_W-1:0]  dls_up [N];

  logic [N-1:0]               valid_q, valid_d;
  logic [dstq_pkg::CNT_W-1:0] count_q, count_d;

  logic                       op_q;
  logic [dstq_pkg::ID_W-1:0]  id_q;
  logic [dstq_pkg::DL_W-1:0]  dl_q;
  logic [N-1:0]               le_q, match_q;
  logic [N-1:0]               le_prev, first_hit, from_hit;
  logic                       full, found;
  logic [dstq_pkg::STAT_W-1:0] status_q, status_d;
  logic [dstq_pkg::COUNT_W-1:0] ecount_q;

  assign full      = valid_q[N-1];
  assign found     = |match_q;
  assign le_prev   = {le_q[N-2:0], 1'b1};
  // isolate the first matching cell, then mark it and everything behind it
  assign first_hit = match_q & (~match_q + N'(1));
  assign from_hit  = ~(first_hit - N'(1));

  always_comb begin
    ids_dn[0] = id_q;
    dls_dn[0] = dl_q;
    for (int k = 1; k < N; k++) begin
      ids_dn[k] = ids_q[k-1];
      dls_dn[k] = dls_q[k-1];
    end
    for (int k = 0; k < N - 1; k++) begin
      ids_up[k] = ids_q[k+1];
      dls_up[k] = dls_q[k+1];
    end
    ids_up[N-1] = ids_q[N-1];
    dls_up[N-1] = dls_q[N-1];
  end

  always_comb begin
    ids_d    = ids_q;
    dls_d    = dls_q;
    valid_d  = valid_q;
    count_d  = count_q;
    status_d = dstq_pkg::ST_DONE;
    if (op_q == dstq_pkg::ACT_INSERT) begin
      if (full) begin
        status_d = dstq_pkg::ST_FULL;
      end else begin
        // keep cells that sort ahead, drop the item into the first gap, push the rest
        for (int k = 0; k < N; k++) begin
          if (!le_q[k]) begin
            ids_d[k] = le_prev[k] ? id_q : ids_dn[k];
            dls_d[k] = le_prev[k] ? dl_q : dls_dn[k];
          end
        end
        valid_d = {valid_q[N-2:0], 1'b1};
        count_d = count_q + dstq_pkg::CNT_W'(1);
      end
    end else begin
      if (!found) begin
        status_d = dstq_pkg::ST_MISSING;
      end else begin
        for (int k = 0; k < N; k++) begin
          if (from_hit[k]) begin
            ids_d[k] = ids_up[k];
            dls_d[k] = dls_up[k];
          end
        end
        valid_d = valid_q >> 1;
        count_d = count_q - dstq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.apply) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= action_i;
      id_q <= task_id_i;
      dl_q <= deadline_i;
      for (int k = 0; k < N; k++) begin
        le_q[k]    <= valid_q[k] && (dls_q[k] <= deadline_i);
        match_q[k] <= valid_q[k] && (ids_q[k] == task_id_i);
      end
    end
    if (cmd_i.apply) begin
      ids_q    <= ids_d;
      dls_q    <= dls_d;
      status_q <= status_d;
      ecount_q <= dstq_pkg::COUNT_W'(count_d);
    end
  end

  assign status_o      = status_q;
  assign entry_count_o = ecount_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dstq_pkg::CNT_W'(N))
    else $error("entry count above depth");
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("valid cells disagree with entry count");
  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & (valid_q + N'(1))) == '0)
    else $error("valid cells not packed at the head");
`endif

endmodule

// ----- rtl/deadline_sorted_task_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_sorted_task_queue
// Earliest-deadline-first task list with insert and remove-by-id commands.
// ----------------------------------------------------------------------------
// For each command, busy_o is high for the cycle after start_i is
// taken, while the cell chain shifts; the result appears on status_o and
// entry_count_o with done_o for exactly one cycle after that and cannot be
// held off, so a new command may be issued in that same cycle. A command runs
// as the registered per-cell compare step followed by the shift step.
// Entries with equal deadlines keep arrival order; removal deletes the first
// matching identifier from the head.
// ----------------------------------------------------------------------------
module deadline_sorted_task_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  output logic                         done_o,
  input  logic                         action_i,
  input  logic [dstq_pkg::ID_W-1:0]    task_id_i,
  input  logic [dstq_pkg::DL_W-1:0]    deadline_i,
  output logic [dstq_pkg::STAT_W-1:0]  status_o,
  output logic [dstq_pkg::COUNT_W-1:0] entry_count_o
);

  dstq_pkg::cmd_t cmd;

  dstq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  dstq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (action_i),
    .task_id_i     (task_id_i),
    .deadline_i    (deadline_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule
